### hw/rtl/stb_pkg.sv
`timescale 1ns / 1ps
package stb_pkg;

	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 128;
	localparam int STORE_CELLS = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;

	localparam int ROWS_W     = 6;
	localparam int COLS_W     = 8;
	localparam int CHAR_W     = 8;
	localparam int POS_W      = 12;
	localparam int STAT_W     = 3;
	localparam int REQ_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// row quotient and divider step counter
	localparam int ROWQ_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DIVK_W = (ROWQ_W > 1) ? $clog2(ROWQ_W) : 1;
	localparam int DIVT_W = COLS_W + ROWQ_W;
	localparam int SIZE_W = $clog2(STORE_CELLS + 1);
	localparam int MV_W   = ROWS_W + COLS_W;

	localparam logic [ROWS_W-1:0] ROWS_RESET  = 6'd24;
	localparam logic [COLS_W-1:0] COLS_RESET  = 8'd80;
	localparam logic [CHAR_W-1:0] BG_RESET    = 8'd32;
	localparam logic [ROWS_W-1:0] ROWS_MAX    = ROWS_W'(MAX_ROWS);
	localparam logic [COLS_W-1:0] COLS_MAX    = COLS_W'(MAX_COLS);
	localparam logic [POS_W-1:0]  CURSOR_HOME = '0;

	typedef enum logic [REQ_W-1:0] {
		REQ_HOME      = 4'd0,
		REQ_FORWARD   = 4'd1,
		REQ_BACK      = 4'd2,
		REQ_UP        = 4'd3,
		REQ_DOWN      = 4'd4,
		REQ_END       = 4'd5,
		REQ_MOVE_TO   = 4'd6,
		REQ_WRITE     = 4'd7,
		REQ_READ_AT   = 4'd8,
		REQ_READ_HERE = 4'd9,
		REQ_CLEAR     = 4'd10
	} req_e_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_RANGE   = 3'd1,
		STAT_NULL    = 3'd2,
		STAT_BOTTOM  = 3'd3,
		STAT_INVALID = 3'd4
	} stat_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_BG   = 2'd2
	} cfg_e_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SIZE,
		ST_SAT,
		ST_EXEC,
		ST_CLEAR,
		ST_DSTART,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_req;
		logic calc_size;
		logic saturate;
		logic exec;
		logic sweep_step;
		logic fill_init;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic div_last;
		logic req_clear;
	} dp_stat_t;

endpackage

### hw/rtl/stb_ram.sv
`timescale 1ns / 1ps
module stb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/stb_ctrl.sv
`timescale 1ns / 1ps
module stb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  stb_pkg::dp_stat_t dp_stat,
	output stb_pkg::cmd_t     cmd
);

	stb_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stb_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			stb_pkg::ST_INIT: begin
				cmd.sweep_step = 1'b1;
				cmd.fill_init  = 1'b1;
				if (dp_stat.sweep_last) begin
					state_d = stb_pkg::ST_IDLE;
				end
			end
			stb_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = stb_pkg::ST_SIZE;
				end
			end
			stb_pkg::ST_SIZE: begin
				cmd.calc_size = 1'b1;
				state_d       = stb_pkg::ST_SAT;
			end
			stb_pkg::ST_SAT: begin
				cmd.saturate = 1'b1;
				state_d      = stb_pkg::ST_EXEC;
			end
			stb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = dp_stat.req_clear ? stb_pkg::ST_CLEAR : stb_pkg::ST_DSTART;
			end
			stb_pkg::ST_CLEAR: begin
				cmd.sweep_step = 1'b1;
				if (dp_stat.sweep_last) begin
					state_d = stb_pkg::ST_DSTART;
				end
			end
			stb_pkg::ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = stb_pkg::ST_DIV;
			end
			stb_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (dp_stat.div_last) begin
					state_d = stb_pkg::ST_DONE;
				end
			end
			stb_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = stb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != stb_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// a waiting word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stb_pkg::ST_INIT) |-> in_stall)
		else $error("input taken during fill pass");

	a_taken_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !cmd.out_load) |=> !out_valid_q)
		else $error("result repeated");

endmodule

### hw/rtl/stb_datapath.sv
`timescale 1ns / 1ps
module stb_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stb_pkg::cmd_t                       cmd,
	output stb_pkg::dp_stat_t                   dp_stat,
	input  logic                                cfg_we,
	input  logic [stb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [stb_pkg::REQ_W-1:0]           req_type,
	input  logic [stb_pkg::ROWS_W-1:0]          row_number,
	input  logic [stb_pkg::COLS_W-1:0]          col_number,
	input  logic [stb_pkg::CHAR_W-1:0]          char_in,
	output logic [stb_pkg::CHAR_W-1:0]          char_out,
	output logic [stb_pkg::POS_W-1:0]           cursor_pos,
	output logic [stb_pkg::ROWS_W-1:0]          cursor_row,
	output logic [stb_pkg::STAT_W-1:0]          status
);

	logic [stb_pkg::ROWS_W-1:0] rows_q;
	logic [stb_pkg::COLS_W-1:0] cols_q;
	logic [stb_pkg::CHAR_W-1:0] bg_q;
	logic [stb_pkg::ROWS_W-1:0] rows_c;
	logic [stb_pkg::COLS_W-1:0] cols_c;

	stb_pkg::req_e_t            req_q;
	logic [stb_pkg::ROWS_W-1:0] row_q;
	logic [stb_pkg::COLS_W-1:0] col_q;
	logic [stb_pkg::CHAR_W-1:0] ch_q;

	logic [stb_pkg::SIZE_W-1:0] size_q;
	logic [stb_pkg::MV_W-1:0]   prod_q;
	logic [stb_pkg::POS_W-1:0]  cursor_q;
	stb_pkg::stat_e_t           stat_q;

	logic [stb_pkg::POS_W-1:0]  rem_q;
	logic [stb_pkg::ROWQ_W-1:0] quot_q;
	logic [stb_pkg::DIVK_W-1:0] div_k_q;
	logic [stb_pkg::DIVT_W-1:0] trial;

	logic [stb_pkg::ADDR_W-1:0] sweep_q;

	logic [stb_pkg::CHAR_W-1:0] char_out_q;
	logic [stb_pkg::POS_W-1:0]  cursor_pos_q;
	logic [stb_pkg::ROWS_W-1:0] cursor_row_q;
	logic [stb_pkg::STAT_W-1:0] status_q;

	logic [stb_pkg::SIZE_W-1:0] cur_w;
	logic [stb_pkg::SIZE_W-1:0] cols_w;
	logic [stb_pkg::POS_W-1:0]  cursor_d;
	stb_pkg::stat_e_t           stat_d;
	logic                       in_range;

	logic                       ram_en;
	logic                       ram_we;
	logic                       wr_char;
	logic [stb_pkg::ADDR_W-1:0] ram_addr;
	logic [stb_pkg::CHAR_W-1:0] ram_wdata;
	logic [stb_pkg::CHAR_W-1:0] ram_rdata;
	logic [stb_pkg::CHAR_W-1:0] fill_char;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= stb_pkg::ROWS_RESET;
			cols_q <= stb_pkg::COLS_RESET;
			bg_q   <= stb_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (stb_pkg::cfg_e_t'(cfg_index))
				stb_pkg::CFG_ROWS: rows_q <= cfg_data[stb_pkg::ROWS_W-1:0];
				stb_pkg::CFG_COLS: cols_q <= cfg_data[stb_pkg::COLS_W-1:0];
				stb_pkg::CFG_BG:   bg_q   <= cfg_data[stb_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// background only matters for the register itself; the reset fill uses its reset value
	always_comb begin
		if (rows_q == '0) begin
			rows_c = stb_pkg::ROWS_W'(1);
		end else if (rows_q > stb_pkg::ROWS_MAX) begin
			rows_c = stb_pkg::ROWS_MAX;
		end else begin
			rows_c = rows_q;
		end
		if (cols_q == '0) begin
			cols_c = stb_pkg::COLS_W'(1);
		end else if (cols_q > stb_pkg::COLS_MAX) begin
			cols_c = stb_pkg::COLS_MAX;
		end else begin
			cols_c = cols_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= stb_pkg::req_e_t'(req_type);
			row_q <= row_number;
			col_q <= col_number;
			ch_q  <= char_in;
		end
		if (cmd.calc_size) begin
			size_q <= stb_pkg::SIZE_W'(stb_pkg::MV_W'(rows_c) * stb_pkg::MV_W'(cols_c));
			prod_q <= stb_pkg::MV_W'(row_q - stb_pkg::ROWS_W'(1)) * stb_pkg::MV_W'(cols_c);
		end
	end

	assign cur_w  = stb_pkg::SIZE_W'(cursor_q);
	assign cols_w = stb_pkg::SIZE_W'(cols_c);
	assign in_range = (row_q != '0) && (row_q <= rows_c) && (col_q != '0) && (col_q <= cols_c);

	always_comb begin
		cursor_d = cursor_q;
		stat_d   = stb_pkg::STAT_OK;
		unique case (req_q)
			stb_pkg::REQ_HOME: begin
				cursor_d = stb_pkg::CURSOR_HOME;
			end
			stb_pkg::REQ_FORWARD: begin
				if (cur_w + stb_pkg::SIZE_W'(1) >= size_q) begin
					cursor_d = stb_pkg::CURSOR_HOME;
				end else begin
					cursor_d = cursor_q + stb_pkg::POS_W'(1);
				end
			end
			stb_pkg::REQ_BACK: begin
				if (cursor_q == stb_pkg::CURSOR_HOME) begin
					cursor_d = stb_pkg::POS_W'(size_q - stb_pkg::SIZE_W'(1));
				end else begin
					cursor_d = cursor_q - stb_pkg::POS_W'(1);
				end
			end
			stb_pkg::REQ_UP: begin
				if (cur_w < cols_w) begin
					cursor_d = stb_pkg::POS_W'(size_q - cols_w + cur_w);
				end else begin
					cursor_d = stb_pkg::POS_W'(cur_w - cols_w);
				end
			end
			stb_pkg::REQ_DOWN: begin
				// bottom row when one more row reaches the screen size
				if (cur_w + cols_w >= size_q) begin
					stat_d = stb_pkg::STAT_BOTTOM;
				end else begin
					cursor_d = stb_pkg::POS_W'(cur_w + cols_w);
				end
			end
			stb_pkg::REQ_END: begin
				cursor_d = stb_pkg::POS_W'(size_q - stb_pkg::SIZE_W'(1));
			end
			stb_pkg::REQ_MOVE_TO, stb_pkg::REQ_READ_AT: begin
				if (!in_range) begin
					stat_d = stb_pkg::STAT_RANGE;
				end else begin
					cursor_d = stb_pkg::POS_W'(prod_q + stb_pkg::MV_W'(col_q)
						- stb_pkg::MV_W'(1));
				end
			end
			stb_pkg::REQ_WRITE: begin
				if (ch_q == '0) begin
					stat_d = stb_pkg::STAT_NULL;
				end
			end
			stb_pkg::REQ_READ_HERE: begin
				cursor_d = cursor_q;
			end
			stb_pkg::REQ_CLEAR: begin
				cursor_d = stb_pkg::CURSOR_HOME;
			end
			default: begin
				stat_d = stb_pkg::STAT_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= stb_pkg::CURSOR_HOME;
		end else if (cmd.saturate) begin
			if (cur_w >= size_q) begin
				cursor_q <= stb_pkg::POS_W'(size_q - stb_pkg::SIZE_W'(1));
			end
		end else if (cmd.exec) begin
			cursor_q <= cursor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			stat_q <= stat_d;
		end
	end

	// restoring divide of the cursor by the width, one quotient bit a cycle
	assign trial = stb_pkg::DIVT_W'(cols_c) << div_k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_k_q <= '0;
		end else if (cmd.div_start) begin
			div_k_q <= stb_pkg::DIVK_W'(stb_pkg::ROWQ_W - 1);
		end else if (cmd.div_step && (div_k_q != '0)) begin
			div_k_q <= div_k_q - stb_pkg::DIVK_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q  <= cursor_q;
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (stb_pkg::DIVT_W'(rem_q) >= trial) begin
				rem_q           <= rem_q - stb_pkg::POS_W'(trial);
				quot_q[div_k_q] <= 1'b1;
			end
		end
	end

	// fill sweep over the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_step) begin
			if (dp_stat.sweep_last) begin
				sweep_q <= '0;
			end else begin
				sweep_q <= sweep_q + stb_pkg::ADDR_W'(1);
			end
		end
	end

	assign fill_char = cmd.fill_init ? stb_pkg::BG_RESET : ch_q;
	assign wr_char   = cmd.exec && (req_q == stb_pkg::REQ_WRITE) && (ch_q != '0);
	assign ram_we    = cmd.sweep_step || wr_char;
	assign ram_en    = ram_we || cmd.div_start;
	assign ram_addr  = cmd.sweep_step ? sweep_q : stb_pkg::ADDR_W'(cursor_q);
	assign ram_wdata = cmd.sweep_step ? fill_char : ch_q;

	stb_ram #(
		.WIDTH (stb_pkg::CHAR_W),
		.DEPTH (stb_pkg::STORE_CELLS)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			char_out_q   <= ram_rdata;
			cursor_pos_q <= cursor_q;
			cursor_row_q <= stb_pkg::ROWS_W'(quot_q) + stb_pkg::ROWS_W'(1);
			status_q     <= stat_q;
		end
	end

	assign dp_stat.sweep_last = (sweep_q == stb_pkg::ADDR_W'(stb_pkg::STORE_CELLS - 1));
	assign dp_stat.div_last   = (div_k_q == '0);
	assign dp_stat.req_clear  = (req_q == stb_pkg::REQ_CLEAR);

	assign char_out   = char_out_q;
	assign cursor_pos = cursor_pos_q;
	assign cursor_row = cursor_row_q;
	assign status     = status_q;

	a_sweep_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_step && dp_stat.sweep_last) |=> (sweep_q == '0))
		else $error("fill sweep did not return to the first cell");

endmodule

### hw/rtl/text_screen_cursor_buffer.sv
`timescale 1ns / 1ps
// An accepted request passes the size, saturate and execute steps, a clear sweep over
// every store cell (4096) where used, the single-port store read and the 5-step row
// divider; input stall stays high until the result word is loaded, one request at a time.
// Reset: cursor home, registers to 24 rows, 80 columns, background 32; the store is then
// filled with 32 by a sweep over every cell while input stall stays high.
module text_screen_cursor_buffer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [stb_pkg::REQ_W-1:0]      req_type,
	input  logic [stb_pkg::ROWS_W-1:0]     row_number,
	input  logic [stb_pkg::COLS_W-1:0]     col_number,
	input  logic [stb_pkg::CHAR_W-1:0]     char_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [stb_pkg::CHAR_W-1:0]     char_out,
	output logic [stb_pkg::POS_W-1:0]      cursor_pos,
	output logic [stb_pkg::ROWS_W-1:0]     cursor_row,
	output logic [stb_pkg::STAT_W-1:0]     status,
	input  logic                           cfg_we,
	input  logic [stb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stb_pkg::CFG_DATA_W-1:0] cfg_data
);

	stb_pkg::cmd_t     cmd;
	stb_pkg::dp_stat_t dp_stat;

	stb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	stb_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dp_stat    (dp_stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.row_number (row_number),
		.col_number (col_number),
		.char_in    (char_in),
		.char_out   (char_out),
		.cursor_pos (cursor_pos),
		.cursor_row (cursor_row),
		.status     (status)
	);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int          HALF_PERIOD  = 6;
	localparam int          RESET_CYCLES = 11;
	localparam int          HOLD_CYCLES  = 250;
	localparam int          QUIET_LIMIT  = 20000;
	localparam int          TAIL_CYCLES  = 30;
	localparam int unsigned HOME_POS     = 32'(stb_pkg::CURSOR_HOME);

	typedef struct {
		logic [stb_pkg::CHAR_W-1:0] ch;
		logic [stb_pkg::POS_W-1:0]  pos;
		logic [stb_pkg::ROWS_W-1:0] row;
		logic [stb_pkg::STAT_W-1:0] st;
	} cursor_word_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic                           in_stall;
	logic [stb_pkg::REQ_W-1:0]      req_type   = '0;
	logic [stb_pkg::ROWS_W-1:0]     row_number = '0;
	logic [stb_pkg::COLS_W-1:0]     col_number = '0;
	logic [stb_pkg::CHAR_W-1:0]     char_in    = '0;
	logic                           out_valid;
	logic                           out_stall  = 1'b0;
	logic [stb_pkg::CHAR_W-1:0]     char_out;
	logic [stb_pkg::POS_W-1:0]      cursor_pos;
	logic [stb_pkg::ROWS_W-1:0]     cursor_row;
	logic [stb_pkg::STAT_W-1:0]     status;
	logic                           cfg_we     = 1'b0;
	logic [stb_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [stb_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

	// shadow copy of the screen
	int unsigned                sh_rows;
	int unsigned                sh_cols;
	logic [stb_pkg::CHAR_W-1:0] sh_bg;
	int unsigned                sh_cursor;
	logic [stb_pkg::CHAR_W-1:0] sh_cells [stb_pkg::STORE_CELLS];

	cursor_word_t cursor_words_q[$];
	int           n_err        = 0;
	int           idle_pct     = 24;
	bit           hold_req     = 1'b0;
	int           hold_left    = 0;
	int           quiet_cycles = 0;

	text_screen_cursor_buffer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.row_number (row_number),
		.col_number (col_number),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_out   (char_out),
		.cursor_pos (cursor_pos),
		.cursor_row (cursor_row),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int unsigned screen_rows();
		return (sh_rows == 0) ? 1 : (sh_rows > stb_pkg::MAX_ROWS) ? stb_pkg::MAX_ROWS : sh_rows;
	endfunction

	function automatic int unsigned screen_cols();
		return (sh_cols == 0) ? 1 : (sh_cols > stb_pkg::MAX_COLS) ? stb_pkg::MAX_COLS : sh_cols;
	endfunction

	function automatic cursor_word_t screen_apply(input logic [stb_pkg::REQ_W-1:0] rq,
			input logic [stb_pkg::ROWS_W-1:0] rw, input logic [stb_pkg::COLS_W-1:0] cl,
			input logic [stb_pkg::CHAR_W-1:0] ch);
		int unsigned  nr;
		int unsigned  nc;
		int unsigned  cells;
		int unsigned  r;
		int unsigned  c;
		cursor_word_t w;
		nr    = screen_rows();
		nc    = screen_cols();
		cells = nr * nc;
		r     = 32'(rw);
		c     = 32'(cl);
		w.st  = stb_pkg::STAT_OK;
		if (sh_cursor >= cells)
			sh_cursor = cells - 1;
		unique case (rq)
			stb_pkg::REQ_HOME: sh_cursor = HOME_POS;
			stb_pkg::REQ_FORWARD:
				sh_cursor = (sh_cursor + 1 >= cells) ? HOME_POS : sh_cursor + 1;
			stb_pkg::REQ_BACK:
				sh_cursor = (sh_cursor == HOME_POS) ? cells - 1 : sh_cursor - 1;
			stb_pkg::REQ_UP:
				sh_cursor = (sh_cursor < nc) ? cells - nc + sh_cursor : sh_cursor - nc;
			stb_pkg::REQ_DOWN: begin
				if (sh_cursor / nc + 1 >= nr)
					w.st = stb_pkg::STAT_BOTTOM;
				else
					sh_cursor += nc;
			end
			stb_pkg::REQ_END: sh_cursor = cells - 1;
			stb_pkg::REQ_MOVE_TO, stb_pkg::REQ_READ_AT: begin
				if (r < 1 || r > nr || c < 1 || c > nc)
					w.st = stb_pkg::STAT_RANGE;
				else
					sh_cursor = (r - 1) * nc + c - 1;
			end
			stb_pkg::REQ_WRITE: begin
				if (ch == 0)
					w.st = stb_pkg::STAT_NULL;
				else
					sh_cells[sh_cursor[stb_pkg::ADDR_W-1:0]] = ch;
			end
			stb_pkg::REQ_READ_HERE: ;
			stb_pkg::REQ_CLEAR: begin
				for (int i = 0; i < stb_pkg::STORE_CELLS; i++)
					sh_cells[i] = ch;
				sh_cursor = HOME_POS;
			end
			default: w.st = stb_pkg::STAT_INVALID;
		endcase
		w.ch  = sh_cells[sh_cursor[stb_pkg::ADDR_W-1:0]];
		w.pos = sh_cursor[stb_pkg::POS_W-1:0];
		w.row = stb_pkg::ROWS_W'(sh_cursor / nc + 1);
		return w;
	endfunction

	task automatic send_req(input logic [stb_pkg::REQ_W-1:0] rq,
			input logic [stb_pkg::ROWS_W-1:0] rw,
			input logic [stb_pkg::COLS_W-1:0] cl, input logic [stb_pkg::CHAR_W-1:0] ch);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		row_number <= rw;
		col_number <= cl;
		char_in    <= ch;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		cursor_words_q.push_back(screen_apply(rq, rw, cl, ch));
	endtask

	// waits until every word owed by the block has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cursor_words_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(input stb_pkg::cfg_e_t idx,
			input logic [stb_pkg::CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			stb_pkg::CFG_ROWS: sh_rows = 32'(v[stb_pkg::ROWS_W-1:0]);
			stb_pkg::CFG_COLS: sh_cols = 32'(v);
			stb_pkg::CFG_BG:   sh_bg = v;
			default:  ;
		endcase
	endtask

	task automatic random_burst(input int n);
		int unsigned                pick;
		int unsigned                nr;
		int unsigned                nc;
		logic [stb_pkg::REQ_W-1:0]  rq;
		logic [stb_pkg::ROWS_W-1:0] rw;
		logic [stb_pkg::COLS_W-1:0] cl;
		logic [stb_pkg::CHAR_W-1:0] ch;
		nr = screen_rows();
		nc = screen_cols();
		repeat (n) begin
			pick = $urandom_range(999);
			rw   = stb_pkg::ROWS_W'($urandom);
			cl   = stb_pkg::COLS_W'($urandom);
			ch   = stb_pkg::CHAR_W'($urandom);
			if (pick < 100)
				rq = stb_pkg::REQ_FORWARD;
			else if (pick < 170)
				rq = stb_pkg::REQ_BACK;
			else if (pick < 240)
				rq = stb_pkg::REQ_UP;
			else if (pick < 330)
				rq = stb_pkg::REQ_DOWN;
			else if (pick < 360)
				rq = stb_pkg::REQ_HOME;
			else if (pick < 390)
				rq = stb_pkg::REQ_END;
			else if (pick < 560)
				rq = stb_pkg::REQ_MOVE_TO;
			else if (pick < 760)
				rq = stb_pkg::REQ_WRITE;
			else if (pick < 880)
				rq = stb_pkg::REQ_READ_AT;
			else if (pick < 950)
				rq = stb_pkg::REQ_READ_HERE;
			else if (pick < 980)
				rq = stb_pkg::REQ_W'($urandom_range(int'(stb_pkg::REQ_CLEAR) + 1,
					2**stb_pkg::REQ_W - 1));
			else if (pick < 990)
				rq = stb_pkg::REQ_CLEAR;
			else begin
				rq = stb_pkg::REQ_WRITE;
				ch = '0;
			end
			if ((rq == stb_pkg::REQ_MOVE_TO || rq == stb_pkg::REQ_READ_AT)
					&& $urandom_range(9) < 8) begin
				rw = stb_pkg::ROWS_W'($urandom_range(nr, 1));
				cl = stb_pkg::COLS_W'($urandom_range(nc, 1));
			end
			send_req(rq, rw, cl, ch);
		end
	endtask

	task automatic test_directed();
		send_req(stb_pkg::REQ_READ_HERE, 0, 0, 0);
		send_req(stb_pkg::REQ_BACK, 63, 255, 255);
		send_req(stb_pkg::REQ_FORWARD, 0, 0, 0);
		send_req(stb_pkg::REQ_UP, 0, 0, 0);
		send_req(stb_pkg::REQ_DOWN, 0, 0, 0);
		send_req(stb_pkg::REQ_HOME, 0, 0, 0);
		send_req(stb_pkg::REQ_DOWN, 0, 0, 0);
		send_req(stb_pkg::REQ_END, 0, 0, 0);
		send_req(stb_pkg::REQ_MOVE_TO, 24, 80, 0);
		send_req(stb_pkg::REQ_MOVE_TO, 0, 5, 0);
		send_req(stb_pkg::REQ_MOVE_TO, 3, 0, 0);
		send_req(stb_pkg::REQ_MOVE_TO, 25, 1, 0);
		send_req(stb_pkg::REQ_MOVE_TO, 63, 255, 0);
		send_req(stb_pkg::REQ_MOVE_TO, 1, 81, 0);
		send_req(stb_pkg::REQ_WRITE, 0, 0, 255);
		send_req(stb_pkg::REQ_WRITE, 63, 255, 0);
		send_req(stb_pkg::REQ_READ_AT, 1, 1, 0);
		send_req(stb_pkg::REQ_READ_AT, 24, 80, 0);
		send_req(stb_pkg::REQ_READ_AT, 0, 0, 0);
		for (int k = int'(stb_pkg::REQ_CLEAR) + 1; k < 2**stb_pkg::REQ_W; k++)
			send_req(stb_pkg::REQ_W'(k), 0, 0, 0);
		send_req(stb_pkg::REQ_CLEAR, 0, 0, 0);
		send_req(stb_pkg::REQ_READ_AT, 12, 40, 0);
		settle();
	endtask

	task automatic test_screen_sizes();
		int rows_set [8] = '{1, 32, 0, 63, 1, 32, 7, 24};
		int cols_set [8] = '{1, 128, 0, 255, 128, 1, 13, 80};
		for (int p = 0; p < 8; p++) begin
			set_reg(stb_pkg::CFG_ROWS, stb_pkg::CFG_DATA_W'(rows_set[p]));
			set_reg(stb_pkg::CFG_COLS, stb_pkg::CFG_DATA_W'(cols_set[p]));
			set_reg(stb_pkg::CFG_BG, (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
			send_req(stb_pkg::REQ_CLEAR, stb_pkg::ROWS_W'($urandom),
				stb_pkg::COLS_W'($urandom), stb_pkg::CHAR_W'($urandom_range(255, 1)));
			random_burst(30);
			settle();
		end
	endtask

	// shrink without a clear so the cursor lands off screen, then grow again
	task automatic test_stale_cursor();
		send_req(stb_pkg::REQ_END, 0, 0, 0);
		settle();
		set_reg(stb_pkg::CFG_ROWS, 3);
		set_reg(stb_pkg::CFG_COLS, 5);
		send_req(stb_pkg::REQ_READ_HERE, 0, 0, 0);
		send_req(stb_pkg::REQ_FORWARD, 0, 0, 0);
		random_burst(20);
		send_req(stb_pkg::REQ_END, 0, 0, 0);
		settle();
		set_reg(stb_pkg::CFG_ROWS, 2);
		send_req(stb_pkg::REQ_BACK, 0, 0, 0);
		settle();
		set_reg(stb_pkg::CFG_ROWS, 32);
		set_reg(stb_pkg::CFG_COLS, 128);
		random_burst(20);
		settle();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		random_burst(30);
		settle();
		random_burst(10);
		settle();
	endtask

	task automatic test_random_traffic();
		idle_pct = 0;
		random_burst(150);
		settle();
		idle_pct = 24;
		repeat (4) begin
			set_reg(stb_pkg::CFG_ROWS, stb_pkg::CFG_DATA_W'($urandom_range(32, 1)));
			set_reg(stb_pkg::CFG_COLS, stb_pkg::CFG_DATA_W'($urandom_range(128, 1)));
			set_reg(stb_pkg::CFG_BG, stb_pkg::CFG_DATA_W'($urandom));
			send_req(stb_pkg::REQ_CLEAR, stb_pkg::ROWS_W'($urandom),
				stb_pkg::COLS_W'($urandom), stb_pkg::CHAR_W'($urandom));
			random_burst(110);
			settle();
		end
	endtask

	initial begin
		sh_rows   = 32'(stb_pkg::ROWS_RESET);
		sh_cols   = 32'(stb_pkg::COLS_RESET);
		sh_bg     = stb_pkg::BG_RESET;
		sh_cursor = HOME_POS;
		for (int i = 0; i < stb_pkg::STORE_CELLS; i++)
			sh_cells[i] = stb_pkg::BG_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_screen_sizes();
		test_stale_cursor();
		test_backpressure();
		test_random_traffic();
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_err == 0 && cursor_words_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin : check_words
		cursor_word_t w;
		if (out_valid === 1'b1 && !out_stall) begin
			if (cursor_words_q.size() == 0) begin
				$error("result word with no request outstanding");
				n_err++;
			end else begin
				w = cursor_words_q.pop_front();
				if (char_out !== w.ch) begin
					$error("char_out: expected %0d, got %0d", w.ch, char_out);
					n_err++;
				end
				if (cursor_pos !== w.pos) begin
					$error("cursor_pos: expected %0d, got %0d", w.pos, cursor_pos);
					n_err++;
				end
				if (cursor_row !== w.row) begin
					$error("cursor_row: expected %0d, got %0d", w.row, cursor_row);
					n_err++;
				end
				if (status !== w.st) begin
					$error("status: expected %0d, got %0d", w.st, status);
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
